@@ src/bfgl_pkg.sv @@
// Shared types and constants for the bitmap font glyph layout block.
`timescale 1ns / 1ps

package bfgl_pkg;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_START = 2'd1,
        CMD_CHAR  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_code_t;

    typedef enum logic [1:0] {
        CFG_GLYPH_HEIGHT  = 2'd0,
        CFG_CELL_WIDTH    = 2'd1,
        CFG_SHEET_COLUMNS = 2'd2,
        CFG_FIRST_CODE    = 2'd3
    } cfg_reg_t;

    localparam logic [6:0]  CODE_SPACE      = 7'd32;
    localparam logic [6:0]  CODE_NEWLINE    = 7'd10;
    localparam logic [11:0] SCALE_ONE       = 12'd256;
    localparam logic [7:0]  COLUMNS_RESET   = 8'd1;
    localparam logic [6:0]  FIRST_CODE_RST  = 7'd32;
    localparam logic [2:0]  DIV_LAST_STEP   = 3'd6;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [6:0]         char_code;
        logic [7:0]         width_value;
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic [11:0]        scale_q4_8;
        logic [31:0]        text_color;
    } cmd_item_t;

    typedef struct packed {
        logic signed [15:0] dest_x;
        logic signed [15:0] dest_y;
        logic [14:0]        src_left;
        logic [14:0]        src_top;
        logic [14:0]        src_right;
        logic [14:0]        src_bottom;
        logic [31:0]        glyph_color;
    } draw_item_t;

    typedef struct packed {
        logic       done;
        logic [6:0] quot;
        logic [7:0] rem;
    } div_res_t;

endpackage

@@ src/bitmap_font_glyph_layout.sv @@
// Top level: command sequencer, shared multiplier and cursor state for glyph layout.
`timescale 1ns / 1ps
//
//  channel   direction  handshake              payload
//  cmd       in         cmd_valid / cmd_stall  cmd_item  (bfgl_pkg::cmd_item_t)
//  draw      out        draw_valid/ draw_stall draw_item (bfgl_pkg::draw_item_t)
//  cfg       in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  Load, start and unused commands, and characters outside the table, finish in the
//  accept cycle. A newline or a space passes through accept, table read and scale
//  multiply; a drawn glyph goes on through the divider (7 quotient steps and the done
//  flag) for index div/mod columns, two multiplies on the shared 8x12 multiplier and
//  the output load.
//  Reset clears the width table through per-entry valid bits; no clearing pass.
//  A waiting result holds the next glyph at its output load, which stalls new commands.

module bitmap_font_glyph_layout #(
    parameter int TABLE_DEPTH = 128
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_stall,
    input  bfgl_pkg::cmd_item_t   cmd_item,
    output logic                  draw_valid,
    input  logic                  draw_stall,
    output bfgl_pkg::draw_item_t  draw_item,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [7:0]            cfg_data
);
    import bfgl_pkg::*;

    localparam int         AW      = $clog2(TABLE_DEPTH);
    localparam logic [8:0] DEPTH_W = 9'(TABLE_DEPTH);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_READ = 7'b0000010,
        S_ADV  = 7'b0000100,
        S_DIV  = 7'b0001000,
        S_LEFT = 7'b0010000,
        S_TOP  = 7'b0100000,
        S_OUT  = 7'b1000000
    } state_t;

    state_t      state_reg, state_next;

    logic [7:0]  glyph_height_reg, cell_width_reg, sheet_columns_reg;
    logic [6:0]  first_code_reg;

    logic [15:0] cursor_x_reg, cursor_x_next;
    logic [15:0] cursor_y_reg, cursor_y_next;
    logic [15:0] origin_x_reg, origin_x_next;
    logic [11:0] scale_reg, scale_next;
    logic [31:0] color_reg, color_next;

    logic [6:0]  code_reg, code_next;
    logic [6:0]  idx_reg, idx_next;
    logic        nl_reg, nl_next;
    logic [11:0] adv_reg, adv_next;
    logic [14:0] left_reg, left_next;
    logic [19:0] prod_reg, prod_next;

    logic        out_valid_reg, out_valid_next;
    draw_item_t  out_reg, out_next;

    logic        accept;
    logic [7:0]  idx_diff;
    logic [8:0]  idx9, code9;
    logic        idx_ok, wr_ok;
    logic        tab_wr, tab_rd;
    logic [7:0]  tab_data;
    logic        div_start;
    div_res_t    div_res;
    logic [7:0]  mul_a;
    logic [11:0] mul_b;
    logic [15:0] right_sum, bottom_sum;

    assign accept    = cmd_valid && (state_reg == S_IDLE);
    assign cmd_stall = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    assign idx_diff = {1'b0, cmd_item.char_code} - {1'b0, first_code_reg};
    assign idx9     = {2'b00, idx_diff[6:0]};
    assign code9    = {2'b00, cmd_item.char_code};
    assign idx_ok   = !idx_diff[7] && (idx9 < DEPTH_W);
    assign wr_ok    = code9 < DEPTH_W;

    assign tab_wr = accept && (cmd_item.cmd == CMD_LOAD) && wr_ok;
    assign tab_rd = accept && (cmd_item.cmd == CMD_CHAR) && idx_ok;

    bfgl_wtab #(
        .DEPTH (TABLE_DEPTH)
    ) u_wtab (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (tab_wr),
        .wr_addr (code9[AW-1:0]),
        .wr_data (cmd_item.width_value),
        .rd_en   (tab_rd),
        .rd_addr (idx9[AW-1:0]),
        .rd_data (tab_data)
    );

    bfgl_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (idx_reg),
        .divisor  (sheet_columns_reg),
        .res      (div_res)
    );

    // shared multiplier operand select
    always_comb
    begin
        mul_a = tab_data;
        mul_b = scale_reg;
        unique case (state_reg)
            S_LEFT:
            begin
                mul_a = div_res.rem;
                mul_b = {4'd0, cell_width_reg};
            end
            S_TOP:
            begin
                mul_a = {1'b0, div_res.quot};
                mul_b = {4'd0, glyph_height_reg};
            end
            default:
            begin
                mul_a = nl_reg ? glyph_height_reg : tab_data;
                mul_b = scale_reg;
            end
        endcase
    end

    assign right_sum  = {1'b0, left_reg} + {8'd0, cell_width_reg};
    assign bottom_sum = {1'b0, prod_reg[14:0]} + {8'd0, glyph_height_reg};

    always_comb
    begin
        state_next     = state_reg;
        cursor_x_next  = cursor_x_reg;
        cursor_y_next  = cursor_y_reg;
        origin_x_next  = origin_x_reg;
        scale_next     = scale_reg;
        color_next     = color_reg;
        code_next      = code_reg;
        idx_next       = idx_reg;
        nl_next        = nl_reg;
        adv_next       = adv_reg;
        left_next      = left_reg;
        prod_next      = 20'(mul_a) * 20'(mul_b);
        out_next       = out_reg;
        out_valid_next = out_valid_reg && draw_stall;
        div_start      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd_item.cmd)
                        CMD_START:
                        begin
                            cursor_x_next = cmd_item.start_x;
                            origin_x_next = cmd_item.start_x;
                            cursor_y_next = cmd_item.start_y;
                            scale_next    = cmd_item.scale_q4_8;
                            color_next    = cmd_item.text_color;
                        end
                        CMD_CHAR:
                        begin
                            code_next = cmd_item.char_code;
                            idx_next  = idx_diff[6:0];
                            nl_next   = (cmd_item.char_code == CODE_NEWLINE);
                            // drop characters that fall outside the table
                            if (cmd_item.char_code == CODE_NEWLINE || idx_ok)
                            begin
                                state_next = S_READ;
                            end
                        end
                        CMD_LOAD:
                        begin
                        end
                        CMD_NONE:
                        begin
                        end
                    endcase
                end
            end
            S_READ:
            begin
                state_next = S_ADV;
            end
            S_ADV:
            begin
                priority if (nl_reg)
                begin
                    cursor_x_next = origin_x_reg;
                    cursor_y_next = cursor_y_reg + {4'd0, prod_reg[19:8]};
                    state_next    = S_IDLE;
                end
                else if (code_reg == CODE_SPACE)
                begin
                    cursor_x_next = cursor_x_reg + {4'd0, prod_reg[19:8]};
                    state_next    = S_IDLE;
                end
                else
                begin
                    adv_next   = prod_reg[19:8];
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_res.done)
                begin
                    state_next = S_LEFT;
                end
            end
            S_LEFT:
            begin
                state_next = S_TOP;
            end
            S_TOP:
            begin
                left_next  = prod_reg[14:0];
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // hold the row product while the output register is busy
                prod_next = prod_reg;
                // hold until the output register is free
                if (!out_valid_reg || !draw_stall)
                begin
                    out_next.dest_x      = cursor_x_reg;
                    out_next.dest_y      = cursor_y_reg;
                    out_next.src_left    = left_reg;
                    out_next.src_top     = prod_reg[14:0];
                    out_next.src_right   = right_sum[14:0];
                    out_next.src_bottom  = bottom_sum[14:0];
                    out_next.glyph_color = color_reg;
                    out_valid_next       = 1'b1;
                    cursor_x_next        = cursor_x_reg + {4'd0, adv_reg};
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            out_valid_reg     <= 1'b0;
            cursor_x_reg      <= 16'd0;
            cursor_y_reg      <= 16'd0;
            origin_x_reg      <= 16'd0;
            scale_reg         <= SCALE_ONE;
            color_reg         <= 32'd0;
            nl_reg            <= 1'b0;
            glyph_height_reg  <= 8'd0;
            cell_width_reg    <= 8'd0;
            sheet_columns_reg <= COLUMNS_RESET;
            first_code_reg    <= FIRST_CODE_RST;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cursor_x_reg  <= cursor_x_next;
            cursor_y_reg  <= cursor_y_next;
            origin_x_reg  <= origin_x_next;
            scale_reg     <= scale_next;
            color_reg     <= color_next;
            nl_reg        <= nl_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_GLYPH_HEIGHT:  glyph_height_reg  <= cfg_data;
                    CFG_CELL_WIDTH:    cell_width_reg    <= cfg_data;
                    CFG_SHEET_COLUMNS: sheet_columns_reg <= cfg_data;
                    CFG_FIRST_CODE:    first_code_reg    <= cfg_data[6:0];
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
        idx_reg  <= idx_next;
        adv_reg  <= adv_next;
        left_reg <= left_next;
        prod_reg <= prod_next;
        out_reg  <= out_next;
    end

    assign draw_valid = out_valid_reg;
    assign draw_item  = out_reg;

endmodule

@@ src/bfgl_wtab.sv @@
// Advance width table: single-port write, registered read, reset-cleared valid bits.
`timescale 1ns / 1ps

module bfgl_wtab #(
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [7:0]               wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [7:0]               rd_data
);
    logic [7:0]       width_mem [DEPTH];
    logic [7:0]       rd_word_reg;
    logic [DEPTH-1:0] vld_reg;
    logic             hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            width_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_word_reg <= width_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            hit_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                hit_reg <= vld_reg[rd_addr];
            end
        end
    end

    // never-written entries read as zero
    assign rd_data = hit_reg ? rd_word_reg : 8'd0;

endmodule

@@ src/bfgl_div.sv @@
// Restoring divider: glyph index by column count, one quotient bit per cycle.
`timescale 1ns / 1ps

module bfgl_div (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [6:0]          dividend,
    input  logic [7:0]          divisor,
    output bfgl_pkg::div_res_t  res
);
    import bfgl_pkg::*;

    logic [7:0] rem_reg, rem_next;
    logic [6:0] quo_reg, quo_next;
    logic [7:0] dvs_reg, dvs_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       busy_reg, busy_next;
    logic       done_reg, done_next;
    logic [8:0] trial;
    logic [8:0] diff;

    assign trial = {rem_reg, quo_reg[6]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = 8'd0;
            quo_next  = dividend;
            // treat a zero column count as one
            dvs_next  = (divisor == 8'd0) ? 8'd1 : divisor;
            cnt_next  = 3'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[8])
            begin
                rem_next = diff[7:0];
                quo_next = {quo_reg[5:0], 1'b1};
            end
            else
            begin
                rem_next = trial[7:0];
                quo_next = {quo_reg[5:0], 1'b0};
            end
            cnt_next = cnt_reg + 3'd1;
            if (cnt_reg == DIV_LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 3'd0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign res.done = done_reg;
    assign res.quot = quo_reg;
    assign res.rem  = rem_reg;

endmodule

@@ src/bfgl_chk.sv @@
// Port-level checker for the glyph layout block, bound to the top level.
`timescale 1ns / 1ps

module bfgl_chk (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  cmd_valid,
    input logic                  cmd_stall,
    input bfgl_pkg::cmd_item_t   cmd_item,
    input logic                  draw_valid,
    input logic                  draw_stall,
    input bfgl_pkg::draw_item_t  draw_item
);
    import bfgl_pkg::*;

    // a stalled result stays offered
    a_draw_hold: assert property (@(posedge clk) disable iff (!rst_n)
        draw_valid && draw_stall |=> draw_valid)
        else $error("draw item dropped while stalled");

    a_draw_stable: assert property (@(posedge clk) disable iff (!rst_n)
        draw_valid && draw_stall |=> $stable(draw_item))
        else $error("stalled draw item changed");

    // load, start and unused commands finish in the accept cycle
    a_short_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall && (cmd_item.cmd != CMD_CHAR) |=> !cmd_stall)
        else $error("non-character command held the block busy");

    // a new result only ever comes out of glyph work
    a_draw_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(draw_valid) |-> $past(cmd_stall))
        else $error("draw item appeared without glyph work");

endmodule

bind bitmap_font_glyph_layout bfgl_chk u_bfgl_chk (.*);
